// ===== src/sptm_pkg.sv =====
// ----------------------------------------------------------------------------
// sptm_pkg
// Shared widths, entry layout and operation codes for the Sv39 page table
// mapper.
// ----------------------------------------------------------------------------
package sptm_pkg;

   localparam int VPN_W        = 27;
   localparam int PPN_W        = 44;
   localparam int IDX_W        = 9;
   localparam int PERM_W       = 10;
   localparam int ENTRY_W      = 64;
   localparam int COUNT_W      = 27;
   localparam int READ_SLOT_W  = 4;
   localparam int USED_W       = 5;
   localparam int ENTRIES_PER_TABLE = 512;

   // pte layout: ppn sits above the ten flag bits
   localparam int PTE_PPN_LSB  = 10;
   localparam int PTE_PPN_MSB  = PTE_PPN_LSB + PPN_W - 1;
   localparam int PTE_V_BIT    = 0;
   localparam int PTE_PAD_W    = ENTRY_W - PPN_W - PERM_W;

   localparam logic FUNC_MAP  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

// ===== src/sptm_ram.sv =====
// ----------------------------------------------------------------------------
// sptm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sptm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sptm_alu.sv =====
// ----------------------------------------------------------------------------
// sptm_alu
// Shared page number adder: pool slot addresses, pointer offsets and the
// running physical page number of a region.
// ----------------------------------------------------------------------------
module sptm_alu
   import sptm_pkg::*;
(
   input  alu_op_type       op,
   input  logic [PPN_W-1:0] a,
   input  logic [PPN_W-1:0] b,
   output logic [PPN_W-1:0] result
);

   always_comb begin
      case (op)
         ALU_ADD: result = a + b;
         ALU_SUB: result = a - b;
         default: result = a;
      endcase
   end

endmodule

// ===== src/sv39_page_table_mapper_core.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_mapper_core
// Builds an Sv39 three-level page table in a private pool of table pages.
// ----------------------------------------------------------------------------
// After reset the block clears its table memory one entry per cycle;
// req_ready stays low meanwhile, while csr writes are taken at any time. A
// read item goes from acceptance through the issue and data states to the
// finish state (straight to finish when read_slot is outside the pool). In a
// map item each page does a root read, a directory read and a leaf write
// through the single table memory port, each directory lookup also passing
// through the shared page number adder. A zero page_count goes straight to
// the finish state. One item is worked on at a time; a finished result
// waits in the output register until taken.
module sv39_page_table_mapper_core
   import sptm_pkg::*;
#(
   parameter int TABLE_PAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [PPN_W-1:0]       csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [VPN_W-1:0]       req_va_page,
   input  logic [PPN_W-1:0]       req_pa_page,
   input  logic [COUNT_W-1:0]     req_page_count,
   input  logic [PERM_W-1:0]      req_perm,
   input  logic [READ_SLOT_W-1:0] req_read_slot,
   input  logic [IDX_W-1:0]       req_read_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_status,
   output logic [ENTRY_W-1:0]     rsp_entry_data,
   output logic [USED_W-1:0]      rsp_tables_used
);

   localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(TABLE_PAGES);
   localparam int NFS_W  = $clog2(TABLE_PAGES + 1);
   localparam int EXT_W  = NFS_W + USED_W;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_RD_ISSUE = 4'd2;
   localparam logic [3:0] ST_RD_DATA  = 4'd3;
   localparam logic [3:0] ST_L1_RD    = 4'd4;
   localparam logic [3:0] ST_L1_CHK   = 4'd5;
   localparam logic [3:0] ST_L2_RD    = 4'd6;
   localparam logic [3:0] ST_L2_CHK   = 4'd7;
   localparam logic [3:0] ST_LEAF     = 4'd8;
   localparam logic [3:0] ST_FINISH   = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clear_addr_ff, clear_addr_in;
   logic [PPN_W-1:0]   base_ff, base_in;
   logic [NFS_W-1:0]   nfs_ff, nfs_in;

   logic [VPN_W-1:0]   va_ff, va_in;
   logic [PPN_W-1:0]   ppn_ff, ppn_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [PERM_W-1:0]  perm_ff, perm_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;
   logic               status_ff, status_in;
   logic [ENTRY_W-1:0] data_ff, data_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_data_ff, rsp_data_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   alu_op_type         alu_op;
   logic [PPN_W-1:0]   alu_a, alu_b, alu_result;

   logic [IDX_W-1:0]   dir_idx;
   logic [SLOT_W-1:0]  dir_slot;
   logic [ADDR_W-1:0]  dir_addr;
   logic               entry_valid;
   logic [EXT_W-1:0]   nfs_ext;
   logic               load_rsp;

   sptm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sptm_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result)
   );

   assign entry_valid = ram_rd_data[PTE_V_BIT];
   assign nfs_ext     = EXT_W'(nfs_ff);

   // root level uses slot zero, the second level the slot found at the root
   always_comb begin
      if (state_ff == ST_L1_RD || state_ff == ST_L1_CHK) begin
         dir_idx  = va_ff[3*IDX_W-1:2*IDX_W];
         dir_slot = '0;
      end else begin
         dir_idx  = va_ff[2*IDX_W-1:IDX_W];
         dir_slot = slot_ff;
      end
      dir_addr = {dir_slot, dir_idx};
   end

   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = base_ff;
      alu_b  = PPN_W'(nfs_ff);
      if (state_ff == ST_LEAF) begin
         alu_a = ppn_ff;
         alu_b = PPN_W'(1);
      end else if (entry_valid) begin
         // pool-relative slot of an existing pointer
         alu_op = ALU_SUB;
         alu_a  = ram_rd_data[PTE_PPN_MSB:PTE_PPN_LSB];
         alu_b  = base_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      base_in       = base_ff;
      nfs_in        = nfs_ff;
      va_in         = va_ff;
      ppn_in        = ppn_ff;
      left_in       = left_ff;
      perm_in       = perm_ff;
      slot_in       = slot_ff;
      ridx_in       = ridx_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = dir_addr;
      ram_wr_data   = '0;
      ram_rd_addr   = dir_addr;
      load_rsp      = 1'b0;

      if (csr_wr_en) begin
         base_in = csr_wr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = clear_addr_ff;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               va_in     = req_va_page;
               ppn_in    = req_pa_page;
               left_in   = req_page_count;
               perm_in   = req_perm;
               slot_in   = SLOT_W'(req_read_slot);
               ridx_in   = req_read_index;
               status_in = 1'b0;
               data_in   = '0;
               if (req_func == FUNC_READ) begin
                  if (int'(req_read_slot) < TABLE_PAGES) begin
                     state_in = ST_RD_ISSUE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else if (req_page_count == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_L1_RD;
               end
            end
         end
         ST_RD_ISSUE: begin
            ram_rd_addr = {slot_ff, ridx_ff};
            state_in    = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            data_in  = ram_rd_data;
            state_in = ST_FINISH;
         end
         ST_L1_RD: begin
            state_in = ST_L1_CHK;
         end
         ST_L2_RD: begin
            state_in = ST_L2_CHK;
         end
         ST_L1_CHK, ST_L2_CHK: begin
            if (!entry_valid) begin
               if (nfs_ff >= NFS_W'(TABLE_PAGES)) begin
                  status_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {{PTE_PAD_W{1'b0}}, alu_result,
                                 {(PERM_W-1){1'b0}}, 1'b1};
                  slot_in     = nfs_ff[SLOT_W-1:0];
                  nfs_in      = nfs_ff + NFS_W'(1);
                  state_in    = (state_ff == ST_L1_CHK) ? ST_L2_RD : ST_LEAF;
               end
            end else if (alu_result < PPN_W'(nfs_ff)) begin
               slot_in  = alu_result[SLOT_W-1:0];
               state_in = (state_ff == ST_L1_CHK) ? ST_L2_RD : ST_LEAF;
            end else begin
               // pointer outside the allocated part of the pool
               status_in = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_LEAF: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {slot_ff, va_ff[IDX_W-1:0]};
            ram_wr_data = {{PTE_PAD_W{1'b0}}, ppn_ff, perm_ff};
            ppn_in      = alu_result;
            va_in       = va_ff + VPN_W'(1);
            left_in     = left_ff - COUNT_W'(1);
            if (left_ff == COUNT_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_L1_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_used_in   = rsp_used_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_data_in   = data_ff;
         rsp_used_in   = nfs_ext[USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         base_ff       <= PPN_W'(524288);
         nfs_ff        <= NFS_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         base_ff       <= base_in;
         nfs_ff        <= nfs_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff         <= va_in;
      ppn_ff        <= ppn_in;
      left_ff       <= left_in;
      perm_ff       <= perm_in;
      slot_ff       <= slot_in;
      ridx_ff       <= ridx_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_data  = rsp_data_ff;
   assign rsp_tables_used = rsp_used_ff;

endmodule

// ===== tb/sv39_page_table_mapper_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_table_mapper_core_tb
// Self-checking bench for the Sv39 page table mapper. A local table-pool
// model predicts status, entry data and slot usage for every accepted item;
// directed items cover wraps, foreign pointers and pool exhaustion, then
// random phases run under several pool base settings, most with random gaps.
// ----------------------------------------------------------------------------
module sv39_page_table_mapper_core_tb
   import sptm_pkg::*;
();

   localparam int TABLE_PAGES  = 16;
   localparam int POOL_ENTRIES = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 28;
   // clearing pass, one exhausting walk of a few thousand pages and a few
   // long random walks dominate; the rest is small
   localparam longint unsigned CYCLE_LIMIT = 3_000_000;
   localparam logic [PPN_W-1:0] RESET_BASE = 44'd524288;
   localparam logic [PPN_W-1:0] TOP_BASE   = '1;

   typedef struct packed {
      logic                   func;
      logic [VPN_W-1:0]       va_page;
      logic [PPN_W-1:0]       pa_page;
      logic [COUNT_W-1:0]     page_count;
      logic [PERM_W-1:0]      perm;
      logic [READ_SLOT_W-1:0] read_slot;
      logic [IDX_W-1:0]       read_index;
   } pt_req_type;

   typedef struct packed {
      logic               status;
      logic [ENTRY_W-1:0] entry_data;
      logic [USED_W-1:0]  tables_used;
   } pt_rsp_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [PPN_W-1:0]       csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_func = FUNC_MAP;
   logic [VPN_W-1:0]       req_va_page = '0;
   logic [PPN_W-1:0]       req_pa_page = '0;
   logic [COUNT_W-1:0]     req_page_count = '0;
   logic [PERM_W-1:0]      req_perm = '0;
   logic [READ_SLOT_W-1:0] req_read_slot = '0;
   logic [IDX_W-1:0]       req_read_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_status;
   logic [ENTRY_W-1:0]     rsp_entry_data;
   logic [USED_W-1:0]      rsp_tables_used;

   sv39_page_table_mapper_core #(
      .TABLE_PAGES(TABLE_PAGES)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_va_page    (req_va_page),
      .req_pa_page    (req_pa_page),
      .req_page_count (req_page_count),
      .req_perm       (req_perm),
      .req_read_slot  (req_read_slot),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_entry_data (rsp_entry_data),
      .rsp_tables_used(rsp_tables_used)
   );

   // local copy of the table pool and allocator
   logic [ENTRY_W-1:0] table_pool [POOL_ENTRIES];
   int unsigned        slots_taken;
   logic [PPN_W-1:0]   pool_base;

   pt_req_type       req_backlog[$];
   pt_rsp_type       awaited_results[$];
   logic [VPN_W-1:0] mapped_vas[$];
   pt_req_type       offered;
   pt_rsp_type       want_rsp;

   int               gap_left = 0;
   int               stall_left = 0;
   int               hold_left = 0;
   bit               gaps_on = 1'b1;
   bit               hold_req = 1'b0;
   bit               base_write_pending = 1'b0;
   logic [PPN_W-1:0] base_to_write = '0;
   int               error_count = 0;
   longint unsigned  cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // follow or create one directory entry; 0 on exhaustion or foreign pointer
   function automatic bit walk_directory(input int unsigned slot,
                                         input logic [IDX_W-1:0] idx,
                                         output int unsigned child);
      int unsigned        pos;
      logic [ENTRY_W-1:0] pte;
      logic [PPN_W-1:0]   ppn;
      pos = slot * ENTRIES_PER_TABLE + idx;
      pte = table_pool[pos];
      child = 0;
      if (!pte[PTE_V_BIT]) begin
         if (slots_taken >= TABLE_PAGES)
            return 1'b0;
         ppn = pool_base + slots_taken;
         pte = '0;
         pte[PTE_PPN_MSB:PTE_PPN_LSB] = ppn;
         pte[PTE_V_BIT] = 1'b1;
         table_pool[pos] = pte;
         child = slots_taken;
         slots_taken++;
         return 1'b1;
      end
      ppn = pte[PTE_PPN_MSB:PTE_PPN_LSB] - pool_base;
      if (ppn >= slots_taken || ppn >= TABLE_PAGES)
         return 1'b0;
      child = 32'(ppn[7:0]);
      return 1'b1;
   endfunction

   function automatic pt_rsp_type resolve_request(input pt_req_type rq);
      pt_rsp_type         rs;
      logic [VPN_W-1:0]   vpn;
      logic [ENTRY_W-1:0] pte;
      int unsigned        mid;
      int unsigned        leaf;
      rs = '0;
      if (rq.func == FUNC_READ) begin
         if (rq.read_slot < TABLE_PAGES)
            rs.entry_data = table_pool[rq.read_slot * ENTRIES_PER_TABLE + rq.read_index];
      end else begin
         for (longint unsigned i = 0; i < rq.page_count; i++) begin
            vpn = rq.va_page + i[VPN_W-1:0];
            if (!walk_directory(0, vpn[2*IDX_W +: IDX_W], mid) ||
                !walk_directory(mid, vpn[IDX_W +: IDX_W], leaf)) begin
               rs.status = 1'b1;
               break;
            end
            pte = '0;
            pte[PTE_PPN_MSB:PTE_PPN_LSB] = rq.pa_page + i[PPN_W-1:0];
            pte[PERM_W-1:0] = rq.perm;
            table_pool[leaf * ENTRIES_PER_TABLE + vpn[IDX_W-1:0]] = pte;
         end
      end
      rs.tables_used = slots_taken[USED_W-1:0];
      return rs;
   endfunction

   function automatic logic [PPN_W-1:0] rand_ppn();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[PPN_W-1:0];
   endfunction

   function automatic pt_req_type scatter_fields();
      pt_req_type rq;
      rq.func       = 1'($urandom_range(0, 1));
      rq.va_page    = VPN_W'($urandom);
      rq.pa_page    = rand_ppn();
      rq.page_count = COUNT_W'($urandom);
      rq.perm       = PERM_W'($urandom);
      rq.read_slot  = READ_SLOT_W'($urandom);
      rq.read_index = IDX_W'($urandom);
      return rq;
   endfunction

   task automatic queue_map(input logic [VPN_W-1:0] va, input logic [PPN_W-1:0] pa,
                            input logic [COUNT_W-1:0] cnt, input logic [PERM_W-1:0] flags);
      pt_req_type rq;
      rq = scatter_fields();
      rq.func       = FUNC_MAP;
      rq.va_page    = va;
      rq.pa_page    = pa;
      rq.page_count = cnt;
      rq.perm       = flags;
      req_backlog.push_back(rq);
      mapped_vas.push_back(va);
   endtask

   task automatic queue_read(input logic [READ_SLOT_W-1:0] slot, input logic [IDX_W-1:0] idx);
      pt_req_type rq;
      rq = scatter_fields();
      rq.func       = FUNC_READ;
      rq.read_slot  = slot;
      rq.read_index = idx;
      req_backlog.push_back(rq);
   endtask

   task automatic add_random_item();
      logic [VPN_W-1:0]   va;
      logic [COUNT_W-1:0] cnt;
      logic [IDX_W-1:0]   idx;
      int                 pick;
      pick = $urandom_range(0, 99);
      va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
      if (pick < 45) begin
         // mostly aim at indices that some mapping has touched
         case ($urandom_range(0, 3))
            0: idx = va[2*IDX_W +: IDX_W];
            1: idx = va[IDX_W +: IDX_W];
            2: idx = va[IDX_W-1:0];
            default: idx = IDX_W'($urandom);
         endcase
         queue_read(READ_SLOT_W'($urandom_range(0, TABLE_PAGES - 1)), idx);
      end else begin
         va  = VPN_W'(va + $urandom_range(0, 600));
         cnt = COUNT_W'($urandom_range(1, 12));
         if (pick >= 90)
            va = VPN_W'($urandom);
         if (pick >= 96)
            cnt = COUNT_W'($urandom);
         else if (pick < 50)
            cnt = '0;
         queue_map(va, rand_ppn(), cnt, PERM_W'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_pool_base(input logic [PPN_W-1:0] value);
      wait_drained();
      base_to_write = value;
      base_write_pending = 1'b1;
      while (base_write_pending)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_wr_en <= 1'b0;
         gap_left = 0;
      end else begin
         if (base_write_pending) begin
            csr_wr_en   <= 1'b1;
            csr_wr_data <= base_to_write;
            pool_base = base_to_write;
            base_write_pending = 1'b0;
         end else begin
            csr_wr_en <= 1'b0;
         end
         if (req_valid && req_ready)
            awaited_results.push_back(resolve_request(offered));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               offered = req_backlog.pop_front();
               req_valid      <= 1'b1;
               req_func       <= offered.func;
               req_va_page    <= offered.va_page;
               req_pa_page    <= offered.pa_page;
               req_page_count <= offered.page_count;
               req_perm       <= offered.perm;
               req_read_slot  <= offered.read_slot;
               req_read_index <= offered.read_index;
               gap_left = gaps_on ? $urandom_range(0, 9) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result item with nothing outstanding: status %0d entry_data %h",
                      rsp_status, rsp_entry_data);
               error_count++;
            end else begin
               want_rsp = awaited_results.pop_front();
               if (rsp_status !== want_rsp.status) begin
                  $error("status: expected %0d actual %0d", want_rsp.status, rsp_status);
                  error_count++;
               end
               if (rsp_entry_data !== want_rsp.entry_data) begin
                  $error("entry_data: expected %h actual %h",
                         want_rsp.entry_data, rsp_entry_data);
                  error_count++;
               end
               if (rsp_tables_used !== want_rsp.tables_used) begin
                  $error("tables_used: expected %0d actual %0d",
                         want_rsp.tables_used, rsp_tables_used);
                  error_count++;
               end
            end
            stall_left = gaps_on ? $urandom_range(0, 9) : 0;
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sv39_page_table_mapper_core verification failed");
      $finish;
   end

   initial begin
      logic [PPN_W-1:0] phase_base;
      foreach (table_pool[i])
         table_pool[i] = '0;
      slots_taken = 1;
      pool_base = RESET_BASE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pool, zero-length map, then both ends of the address space
      queue_read(4'd0, 9'd0);
      queue_map(VPN_W'($urandom), rand_ppn(), '0, PERM_W'($urandom));
      queue_map('0, '0, 27'd1, '0);
      // top vpn wraps to zero, top ppn wraps to zero
      queue_map('1, '1, 27'd2, '1);
      queue_read(4'd0, 9'd0);
      queue_read(4'd0, 9'd511);
      queue_read(4'd2, 9'd0);
      queue_read(4'd4, 9'd511);
      queue_read(4'd15, 9'd511);
      queue_read(4'd3, 9'd511);

      // old root pointers now fall outside the pool; new slots wrap the ppn
      set_pool_base(TOP_BASE);
      queue_map('0, rand_ppn(), 27'd1, PERM_W'($urandom));
      queue_map({9'd1, 9'd0, 9'd0}, rand_ppn(), 27'd3, 10'h0cf);
      queue_read(4'd0, 9'd1);
      // run the pool dry; the last directory entry stays behind
      queue_map({9'd2, 9'd505, 9'd0}, rand_ppn(), '1, PERM_W'($urandom));
      queue_read(4'd0, 9'd3);
      queue_read(4'd15, 9'd0);
      queue_read(4'd14, 9'd511);
      queue_map({9'd1, 9'd0, 9'd3}, rand_ppn(), 27'd2, PERM_W'($urandom));
      queue_map({9'd64, 9'd0, 9'd0}, rand_ppn(), 27'd1, PERM_W'($urandom));

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: phase_base = TOP_BASE;
            1: phase_base = RESET_BASE;
            2: phase_base = '0;
            // small offset makes pointers alias onto other pool slots
            3: phase_base = RESET_BASE + $urandom_range(1, 3);
            4: phase_base = rand_ppn();
            default: phase_base = TOP_BASE;
         endcase
         set_pool_base(phase_base);
         gaps_on = (ph != 3);
         if (ph == 2)
            hold_req = 1'b1;
         repeat (PHASE_ITEMS) add_random_item();
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("sv39_page_table_mapper_core verification clean");
      else
         $display("sv39_page_table_mapper_core verification failed");
      $finish;
   end

endmodule
